### rtl/core/jssb_pkg.sv
// Shared constants, widths and codes for the job shop schedule builder.
package jssb_pkg;
  localparam int MAX_JOBS      = 32;
  localparam int MAX_MACHINES  = 16;
  localparam int DURATION_BITS = 16;

  localparam int STORE_DEPTH = MAX_JOBS * MAX_MACHINES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int JOB_W       = $clog2(MAX_JOBS);
  localparam int MACH_W      = $clog2(MAX_MACHINES);
  localparam int JCNT_W      = $clog2(MAX_JOBS + 1);
  localparam int MCNT_W      = $clog2(MAX_MACHINES + 1);
  localparam int REM_W       = $clog2(STORE_DEPTH + 1);
  localparam int TIME_W      = 26;
  localparam int MKSP_W      = 25;
  localparam int ROUTE_W     = MACH_W + DURATION_BITS;

  localparam int IN_W  = 48;
  localparam int OUT_W = 32;
  localparam int CFG_W = 6;

  localparam logic [MKSP_W-1:0] MAKESPAN_MAX = '1;

  localparam logic [1:0] REQ_LOAD_TASK  = 2'd0;
  localparam logic [1:0] REQ_LOAD_ORDER = 2'd1;
  localparam logic [1:0] REQ_RUN        = 2'd2;
  localparam logic [1:0] REQ_READ       = 2'd3;

  localparam logic CFG_JOB_COUNT     = 1'b0;
  localparam logic CFG_MACHINE_COUNT = 1'b1;
endpackage

### rtl/core/jssb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jssb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/job_shop_schedule_builder.sv
// Top level: table loads, semi-active schedule build and permutation read-back.
//
//  channel | direction | payload
//  in_     | slave     | in_tdata: request item (fields listed at the port)
//  out_    | master    | out_tdata: status, makespan, perm_job
//  cfg_    | write     | cfg_addr 0 job_count, 1 machine_count
//
// Load items are answered straight from idle; read items pass through a read state for the perm RAM read.
// A run starts from idle, then visits each machine once per pass through the order RAM read,
// route RAM read and place states, and ends in a closing state that posts the result.
// Reset is synchronous; RAM contents are not cleared, per-run tables are.
// An item is taken only when the builder is idle and the output register is empty or draining.
module job_shop_schedule_builder
  import jssb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // req_type[1:0], job_id[6:2], task_step[10:7], machine_id[14:11],
  // task_duration[30:15], order_pos[35:31], perm_index[44:36], zero fill
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status[0], makespan[25:1], perm_job[30:26], zero fill
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ORD  = 3'd2;
  localparam logic [2:0] S_JOB  = 3'd3;
  localparam logic [2:0] S_RTE  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [1:0]               f_req;
  logic [4:0]               f_job;
  logic [3:0]               f_step;
  logic [3:0]               f_mach;
  logic [15:0]              f_dur;
  logic [4:0]               f_pos;
  logic [8:0]               f_pidx;

  assign f_req  = in_tdata[1:0];
  assign f_job  = in_tdata[6:2];
  assign f_step = in_tdata[10:7];
  assign f_mach = in_tdata[14:11];
  assign f_dur  = in_tdata[30:15];
  assign f_pos  = in_tdata[35:31];
  assign f_pidx = in_tdata[44:36];

  logic [2:0]               state_r, state_nxt;
  logic [5:0]               job_count_r;
  logic [4:0]               machine_count_r;
  logic [JCNT_W-1:0]        jc_r, jc_nxt;
  logic [MCNT_W-1:0]        mc_r, mc_nxt;
  logic [MACH_W-1:0]        m_r, m_nxt;
  logic                     prog_r, prog_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [ADDR_W:0]          placed_r, placed_nxt;
  logic [TIME_W-1:0]        best_r, best_nxt;
  logic                     last_status_r, last_status_nxt;
  logic [MKSP_W-1:0]        last_mk_r, last_mk_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_data_r, out_data_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic [JOB_W-1:0]         job_r, job_nxt;

  logic [MCNT_W-1:0]        jns_r [MAX_JOBS];
  logic [TIME_W-1:0]        jft_r [MAX_JOBS];
  logic [JCNT_W-1:0]        mnp_r [MAX_MACHINES];
  logic [TIME_W-1:0]        mft_r [MAX_MACHINES];

  logic                     accept;
  logic                     clear_tbl;
  logic                     place;

  logic                     rte_we, ord_we, perm_we;
  logic [ADDR_W-1:0]        rte_waddr, ord_waddr, perm_waddr;
  logic [ADDR_W-1:0]        rte_raddr, ord_raddr, perm_raddr;
  logic [ROUTE_W-1:0]       rte_wdata, rte_rdata;
  logic [JOB_W-1:0]         ord_wdata, ord_rdata, perm_rdata;

  logic [MACH_W-1:0]        rt_mach;
  logic [DURATION_BITS-1:0] rt_dur;
  logic [TIME_W-1:0]        start_t;
  logic [MCNT_W-1:0]        oj_step;
  logic                     m_last;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rt_mach = rte_rdata[MACH_W-1:0];
  assign rt_dur  = rte_rdata[ROUTE_W-1:MACH_W];
  assign start_t = ((mft_r[m_r] > jft_r[job_r]) ? mft_r[m_r] : jft_r[job_r])
                   + TIME_W'(rt_dur);
  assign oj_step = jns_r[ord_rdata];
  assign m_last  = (MCNT_W'(m_r) + MCNT_W'(1)) == mc_r;
  assign place   = (state_r == S_RTE) && (rt_mach == m_r);

  assign rte_we    = accept && (f_req == REQ_LOAD_TASK) &&
                     (int'(f_job) < MAX_JOBS) && (int'(f_step) < MAX_MACHINES);
  assign rte_waddr = ADDR_W'(int'(f_job) * MAX_MACHINES + int'(f_step));
  assign rte_wdata = {DURATION_BITS'(f_dur), MACH_W'(f_mach)};
  assign rte_raddr = ADDR_W'(int'(ord_rdata) * MAX_MACHINES
                     + int'(oj_step[MACH_W-1:0]));

  assign ord_we    = accept && (f_req == REQ_LOAD_ORDER) &&
                     (int'(f_mach) < MAX_MACHINES) && (int'(f_pos) < MAX_JOBS);
  assign ord_waddr = ADDR_W'(int'(f_mach) * MAX_JOBS + int'(f_pos));
  assign ord_wdata = JOB_W'(f_job);
  assign ord_raddr = ADDR_W'(int'(m_r) * MAX_JOBS + int'(mnp_r[m_r][JOB_W-1:0]));

  assign perm_we    = place && (int'(placed_r) < STORE_DEPTH);
  assign perm_waddr = placed_r[ADDR_W-1:0];
  assign perm_raddr = ADDR_W'(f_pidx);

  assign clear_tbl = accept && (f_req == REQ_RUN);

  jssb_ram #(.WIDTH(ROUTE_W), .DEPTH(STORE_DEPTH)) u_route_ram (
    .clk   (clk),
    .we    (rte_we),
    .waddr (rte_waddr),
    .wdata (rte_wdata),
    .raddr (rte_raddr),
    .rdata (rte_rdata)
  );

  jssb_ram #(.WIDTH(JOB_W), .DEPTH(STORE_DEPTH)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  jssb_ram #(.WIDTH(JOB_W), .DEPTH(STORE_DEPTH)) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (job_r),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  always_comb begin
    logic [REM_W-1:0] rem_now;
    logic             prog_now;
    logic             adv;
    state_nxt       = state_r;
    jc_nxt          = jc_r;
    mc_nxt          = mc_r;
    m_nxt           = m_r;
    prog_nxt        = prog_r;
    rem_nxt         = rem_r;
    placed_nxt      = placed_r;
    best_nxt        = best_r;
    last_status_nxt = last_status_r;
    last_mk_nxt     = last_mk_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    rd_ok_nxt       = rd_ok_r;
    job_nxt         = job_r;
    adv             = 1'b0;
    rem_now         = rem_r;
    prog_now        = prog_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (f_req)
            REQ_LOAD_TASK, REQ_LOAD_ORDER: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = OUT_W'({last_mk_r, last_status_r});
            end
            REQ_READ: begin
              rd_ok_nxt = int'(f_pidx) < STORE_DEPTH;
              state_nxt = S_RD;
            end
            default: begin
              jc_nxt          = (int'(job_count_r) > MAX_JOBS) ? JCNT_W'(MAX_JOBS)
                                                               : JCNT_W'(job_count_r);
              mc_nxt          = (int'(machine_count_r) > MAX_MACHINES)
                                ? MCNT_W'(MAX_MACHINES) : MCNT_W'(machine_count_r);
              rem_nxt         = REM_W'(int'(jc_nxt) * int'(mc_nxt));
              m_nxt           = '0;
              prog_nxt        = 1'b0;
              placed_nxt      = '0;
              best_nxt        = '0;
              last_status_nxt = 1'b0;
              state_nxt       = (rem_nxt == '0) ? S_FIN : S_ORD;
            end
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = OUT_W'({(rd_ok_r ? perm_rdata : JOB_W'(0)), last_mk_r,
                               last_status_r});
        state_nxt     = S_IDLE;
      end
      S_ORD: begin
        if (mnp_r[m_r] >= jc_r) begin
          adv = 1'b1;
        end else begin
          state_nxt = S_JOB;
        end
      end
      S_JOB: begin
        if ((JCNT_W'(ord_rdata) >= jc_r) || (oj_step >= mc_r)) begin
          adv = 1'b1;
        end else begin
          job_nxt   = ord_rdata;
          state_nxt = S_RTE;
        end
      end
      S_RTE: begin
        adv = 1'b1;
        if (place) begin
          rem_now    = rem_r - REM_W'(1);
          prog_now   = 1'b1;
          rem_nxt    = rem_now;
          prog_nxt   = 1'b1;
          placed_nxt = placed_r + (ADDR_W+1)'(1);
          if (start_t > best_r) begin
            best_nxt = start_t;
          end
        end
      end
      S_FIN: begin
        last_mk_nxt   = (best_r > TIME_W'(MAKESPAN_MAX)) ? MAKESPAN_MAX
                                                         : MKSP_W'(best_r);
        out_valid_nxt = 1'b1;
        out_data_nxt  = OUT_W'({last_mk_nxt, last_status_r});
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      priority if (!m_last) begin
        m_nxt     = m_r + MACH_W'(1);
        state_nxt = S_ORD;
      end else if (rem_now == '0) begin
        state_nxt = S_FIN;
      end else if (!prog_now) begin
        last_status_nxt = 1'b1;
        state_nxt       = S_FIN;
      end else begin
        m_nxt     = '0;
        prog_nxt  = 1'b0;
        state_nxt = S_ORD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      job_count_r     <= 6'd32;
      machine_count_r <= 5'd16;
      last_status_r   <= 1'b0;
      last_mk_r       <= '0;
      out_valid_r     <= 1'b0;
      jc_r            <= '0;
      mc_r            <= '0;
      m_r             <= '0;
      prog_r          <= 1'b0;
      rem_r           <= '0;
      placed_r        <= '0;
      best_r          <= '0;
    end else begin
      state_r       <= state_nxt;
      last_status_r <= last_status_nxt;
      last_mk_r     <= last_mk_nxt;
      out_valid_r   <= out_valid_nxt;
      jc_r          <= jc_nxt;
      mc_r          <= mc_nxt;
      m_r           <= m_nxt;
      prog_r        <= prog_nxt;
      rem_r         <= rem_nxt;
      placed_r      <= placed_nxt;
      best_r        <= best_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_JOB_COUNT:     job_count_r     <= cfg_wdata;
          CFG_MACHINE_COUNT: machine_count_r <= cfg_wdata[4:0];
          default:           job_count_r     <= job_count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rd_ok_r    <= rd_ok_nxt;
    job_r      <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_tbl) begin
      for (int j = 0; j < MAX_JOBS; j++) begin
        jns_r[j] <= '0;
        jft_r[j] <= '0;
      end
      for (int k = 0; k < MAX_MACHINES; k++) begin
        mnp_r[k] <= '0;
        mft_r[k] <= '0;
      end
    end else if (place) begin
      jns_r[job_r] <= jns_r[job_r] + MCNT_W'(1);
      jft_r[job_r] <= start_t;
      mnp_r[m_r]   <= mnp_r[m_r] + JCNT_W'(1);
      mft_r[m_r]   <= start_t;
    end
  end
endmodule

### verif/job_shop_schedule_builder_chk.sv
// Checker for the job shop schedule builder: predicts each result item and compares it.
`timescale 1ns / 1ps
module job_shop_schedule_builder_chk
  import jssb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output logic             idle
);

  typedef struct packed {
    logic              status;
    logic [MKSP_W-1:0] makespan;
    logic [JOB_W-1:0]  perm_job;
  } sched_result_t;

  sched_result_t             pending_results[$];
  logic [MACH_W-1:0]         route_mach [STORE_DEPTH];
  logic [DURATION_BITS-1:0]  route_dur  [STORE_DEPTH];
  logic [JOB_W-1:0]          order_job  [STORE_DEPTH];
  logic [JOB_W-1:0]          perm_mem   [STORE_DEPTH];
  logic [5:0]                job_cnt;
  logic [4:0]                mach_cnt;
  logic                      last_status;
  logic [MKSP_W-1:0]         last_makespan;

  initial begin
    fail_count = 0;
    idle = 1'b1;
  end

  task automatic build_schedule();
    int jc, mc, remaining, placed, pos, job, step, slot;
    int mpos [MAX_MACHINES];
    int jstep [MAX_JOBS];
    logic [TIME_W-1:0] mfree [MAX_MACHINES];
    logic [TIME_W-1:0] jfree [MAX_JOBS];
    logic [TIME_W-1:0] start, best;
    bit progress;
    jc = (job_cnt > MAX_JOBS) ? MAX_JOBS : job_cnt;
    mc = (mach_cnt > MAX_MACHINES) ? MAX_MACHINES : mach_cnt;
    remaining = jc * mc;
    placed = 0;
    best = '0;
    for (int i = 0; i < MAX_MACHINES; i++) begin
      mpos[i] = 0;
      mfree[i] = '0;
    end
    for (int i = 0; i < MAX_JOBS; i++) begin
      jstep[i] = 0;
      jfree[i] = '0;
    end
    last_status = 1'b0;
    while (remaining > 0) begin
      progress = 1'b0;
      for (int m = 0; m < mc; m++) begin
        pos = mpos[m];
        if (pos >= jc) continue;
        job = order_job[m * MAX_JOBS + pos];
        if (job >= jc) continue;
        step = jstep[job];
        if (step >= mc) continue;
        slot = job * MAX_MACHINES + step;
        if (route_mach[slot] != m) continue;
        start = (mfree[m] > jfree[job]) ? mfree[m] : jfree[job];
        start = start + route_dur[slot];
        mfree[m] = start;
        jfree[job] = start;
        if (placed < STORE_DEPTH) perm_mem[placed] = JOB_W'(job);
        placed++;
        mpos[m] = pos + 1;
        jstep[job] = step + 1;
        remaining--;
        progress = 1'b1;
      end
      if (remaining > 0 && !progress) begin
        last_status = 1'b1;
        break;
      end
    end
    for (int m = 0; m < mc; m++)
      if (mfree[m] > best) best = mfree[m];
    last_makespan = (best > MAKESPAN_MAX) ? MAKESPAN_MAX : best[MKSP_W-1:0];
  endtask

  task automatic predict_item(input logic [IN_W-1:0] d);
    logic [1:0]    req;
    logic [4:0]    job;
    logic [3:0]    step, mach;
    logic [15:0]   dur;
    logic [4:0]    pos;
    logic [8:0]    pidx;
    sched_result_t r;
    req  = d[1:0];
    job  = d[6:2];
    step = d[10:7];
    mach = d[14:11];
    dur  = d[30:15];
    pos  = d[35:31];
    pidx = d[44:36];
    r.perm_job = '0;
    case (req)
      REQ_LOAD_TASK: begin
        route_mach[job * MAX_MACHINES + step] = mach;
        route_dur[job * MAX_MACHINES + step] = dur;
      end
      REQ_LOAD_ORDER: begin
        order_job[mach * MAX_JOBS + pos] = job;
      end
      REQ_RUN: begin
        build_schedule();
      end
      default: begin
        if (pidx < STORE_DEPTH) r.perm_job = perm_mem[pidx];
      end
    endcase
    r.status = last_status;
    r.makespan = last_makespan;
    pending_results.insert(pending_results.size(), r);
  endtask

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst_n) begin
      job_cnt = 6'd32;
      mach_cnt = 5'd16;
      last_status = 1'b0;
      last_makespan = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_JOB_COUNT) job_cnt = cfg_wdata[5:0];
        else mach_cnt = cfg_wdata[4:0];
      end
      if (in_tvalid && in_tready) predict_item(in_tdata);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item: tdata %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_tdata[0] !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[25:1] !== exp_r.makespan) begin
            $error("makespan: expected %0d, actual %0d", exp_r.makespan, out_tdata[25:1]);
            fail_count++;
          end
          if (out_tdata[30:26] !== exp_r.perm_job) begin
            $error("perm_job: expected %0d, actual %0d", exp_r.perm_job, out_tdata[30:26]);
            fail_count++;
          end
        end
      end
    end
    idle = (pending_results.size() == 0);
  end

endmodule

### verif/job_shop_schedule_builder_tb.sv
// Testbench top for the job shop schedule builder: stimulus, idling and verdict.
`timescale 1ns / 1ps
module job_shop_schedule_builder_tb;
  import jssb_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 20000000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic             cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  logic             sched_idle;

  int sent_items = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int cycles = 0;

  int route_of [MAX_JOBS][MAX_MACHINES];
  int order_of [MAX_MACHINES][MAX_JOBS];

  job_shop_schedule_builder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  job_shop_schedule_builder_chk i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .idle(sched_idle)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL job_shop_schedule_builder");
      $finish;
    end
  end

  function automatic int pick_duration();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    return $urandom_range(65535);
  endfunction

  task automatic set_phase();
    case ((sent_items / 150) % 4)
      0: begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      1: begin
        in_idle_pct = 79;
        out_idle_pct = 0;
      end
      2: begin
        in_idle_pct = 0;
        out_idle_pct = 79;
      end
      default: begin
        in_idle_pct = 13;
        out_idle_pct = 13;
      end
    endcase
  endtask

  task automatic send_req(input int req, input int job, input int step,
                          input int mach, input int dur,
                          input int pos, input int pidx);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, 9'(pidx), 5'(pos), 16'(dur), 4'(mach), 4'(step), 5'(job), 2'(req)};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    set_phase();
  endtask

  task automatic send_run();
    send_req(int'(REQ_RUN), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_read(input int idx);
    send_req(int'(REQ_READ), $urandom, $urandom, $urandom, $urandom, $urandom, idx);
  endtask

  task automatic write_reg(input logic addr, input int value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!sched_idle) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // route each job through a shuffled machine list; derive machine orders
  // from one random dispatch sequence so the instance cannot deadlock
  task automatic run_instance(input int jc, input int mc, input bit corrupt);
    int next_step [MAX_JOBS];
    int fill [MAX_MACHINES];
    int left, j, k, tmp;
    for (j = 0; j < jc; j++) begin
      for (k = 0; k < mc; k++) route_of[j][k] = k;
      for (k = mc - 1; k > 0; k--) begin
        tmp = $urandom_range(k);
        {route_of[j][k], route_of[j][tmp]} = {route_of[j][tmp], route_of[j][k]};
      end
      next_step[j] = 0;
    end
    for (k = 0; k < mc; k++) fill[k] = 0;
    left = jc * mc;
    while (left > 0) begin
      j = $urandom_range(jc - 1);
      if (next_step[j] < mc) begin
        k = route_of[j][next_step[j]];
        order_of[k][fill[k]] = j;
        fill[k]++;
        next_step[j]++;
        left--;
      end
    end
    write_reg(CFG_JOB_COUNT, jc);
    write_reg(CFG_MACHINE_COUNT, mc);
    for (j = 0; j < jc; j++)
      for (k = 0; k < mc; k++)
        send_req(int'(REQ_LOAD_TASK), j, k, route_of[j][k], pick_duration(), $urandom,
                 $urandom);
    for (k = 0; k < mc; k++)
      for (j = 0; j < jc; j++)
        send_req(int'(REQ_LOAD_ORDER), order_of[k][j], $urandom, k, $urandom, j, $urandom);
    if (corrupt)
      send_req($urandom_range(1), $urandom_range(jc), $urandom_range(mc - 1),
               $urandom_range(mc), pick_duration(), $urandom_range(jc - 1), $urandom);
    send_run();
    repeat ($urandom_range(1, 4)) send_read($urandom_range(jc * mc - 1));
  endtask

  initial begin
    int order_perm [MAX_JOBS];
    int tmp, r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-size flow shop fills every table entry and the whole permutation
    for (int i = 0; i < MAX_JOBS; i++) order_perm[i] = i;
    for (int i = MAX_JOBS - 1; i > 0; i--) begin
      tmp = $urandom_range(i);
      {order_perm[i], order_perm[tmp]} = {order_perm[tmp], order_perm[i]};
    end
    for (int j = 0; j < MAX_JOBS; j++)
      for (int s = 0; s < MAX_MACHINES; s++)
        send_req(int'(REQ_LOAD_TASK), j, s, s, pick_duration(), $urandom, $urandom);
    for (int m = 0; m < MAX_MACHINES; m++)
      for (int p = 0; p < MAX_JOBS; p++)
        send_req(int'(REQ_LOAD_ORDER), order_perm[p], $urandom, m, $urandom, p, $urandom);
    send_run();
    send_read(0);
    send_read(STORE_DEPTH - 1);

    // empty runs, clamped counts, single operation, deadlock by bad order and by bad route
    write_reg(CFG_JOB_COUNT, 0);
    send_run();
    write_reg(CFG_JOB_COUNT, 63);
    write_reg(CFG_MACHINE_COUNT, 31);
    send_run();
    send_read(STORE_DEPTH - 1);
    write_reg(CFG_MACHINE_COUNT, 0);
    send_run();
    write_reg(CFG_JOB_COUNT, 1);
    write_reg(CFG_MACHINE_COUNT, 1);
    send_req(int'(REQ_LOAD_TASK), 0, 0, 0, 65535, $urandom, $urandom);
    send_req(int'(REQ_LOAD_ORDER), 0, $urandom, 0, $urandom, 0, $urandom);
    send_run();
    send_read(0);
    send_read(5);
    send_req(int'(REQ_LOAD_ORDER), 31, $urandom, 0, $urandom, 0, $urandom);
    send_run();
    send_req(int'(REQ_LOAD_ORDER), 0, $urandom, 0, $urandom, 0, $urandom);
    send_req(int'(REQ_LOAD_TASK), 0, 0, 15, 0, $urandom, $urandom);
    send_run();

    while (sent_items < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 55) begin
        run_instance($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(3) == 0);
      end else if (r < 90) begin
        repeat (10)
          send_req($urandom, $urandom, $urandom, $urandom, pick_duration(),
                   $urandom, $urandom);
      end else begin
        case ($urandom_range(3))
          0: write_reg(CFG_JOB_COUNT, 0);
          1: write_reg(CFG_JOB_COUNT, 63);
          default: write_reg(CFG_JOB_COUNT, $urandom);
        endcase
        case ($urandom_range(3))
          0: write_reg(CFG_MACHINE_COUNT, 1);
          1: write_reg(CFG_MACHINE_COUNT, 63);
          default: write_reg(CFG_MACHINE_COUNT, $urandom);
        endcase
        send_run();
        send_read($urandom);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!sched_idle) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS job_shop_schedule_builder");
    end else begin
      $display("FAIL job_shop_schedule_builder");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/jssb_pkg.sv
rtl/core/jssb_ram.sv
rtl/core/job_shop_schedule_builder.sv
verif/job_shop_schedule_builder_chk.sv
verif/job_shop_schedule_builder_tb.sv
